// ----- hdl/ugip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugip_pkg: shared definitions for the undirected graph path block
// Opcodes, error codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ugip_pkg;

   // opcodes
   localparam logic [2:0] OP_ADD_EDGE    = 3'd0;
   localparam logic [2:0] OP_DEL_EDGE    = 3'd1;
   localparam logic [2:0] OP_EDGE_QUERY  = 3'd2;
   localparam logic [2:0] OP_PATH_QUERY  = 3'd3;
   localparam logic [2:0] OP_APPEND      = 3'd4;
   localparam logic [2:0] OP_DEL_VERTEX  = 3'd5;

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_INDEX = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ADDR_SRC,
      ADDR_TGT,
      ADDR_PICK,
      ADDR_SHIFT_RD,
      ADDR_SHIFT_WR
   } ugip_addr_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SET,
      WR_CLR,
      WR_SHIFT
   } ugip_wr_type;

   typedef struct packed {
      logic          cfg_load;
      logic          item_load;
      logic          rd_en;
      ugip_addr_type addr_sel;
      ugip_wr_type   wr_op;
      logic          reach_init;
      logic          pick;
      logic          merge;
      logic          answer_edge;
      logic          answer_path;
      logic          row_init;
      logic          row_step;
      logic          drop_last;
      logic          count_inc;
      logic          rsp_load;
   } ugip_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] err;
      logic       pending_any;
      logic       shift_more;
      logic       rsp_free;
   } ugip_status_type;

endpackage

// ----- hdl/ugip_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugip_ctrl: sequencer for the undirected graph path block
// Steps each transaction through matrix reads, writes and the frontier loop.
// ----------------------------------------------------------------------------
module ugip_ctrl
   import ugip_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  ugip_status_type status,
   output ugip_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_EDGE_WR_A,
      S_EDGE_RD_B,
      S_EDGE_WR_B,
      S_QUERY_ANS,
      S_PATH_PICK,
      S_PATH_MERGE,
      S_PATH_ANS,
      S_SHIFT_CHECK,
      S_SHIFT_WR,
      S_RESULT
   } state_type;

   state_type   state_ff, state_in;
   ugip_wr_type edge_wr;

   assign edge_wr   = (status.op == OP_ADD_EDGE) ? WR_SET : WR_CLR;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE) || csr_valid;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               cmd.cfg_load = 1'b1;
            end else if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.err != ERR_OK) begin
               state_in = S_RESULT;
            end else begin
               unique case (status.op)
                  OP_ADD_EDGE, OP_DEL_EDGE: begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = ADDR_SRC;
                     state_in     = S_EDGE_WR_A;
                  end
                  OP_EDGE_QUERY: begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = ADDR_SRC;
                     state_in     = S_QUERY_ANS;
                  end
                  OP_PATH_QUERY: begin
                     cmd.reach_init = 1'b1;
                     state_in       = S_PATH_PICK;
                  end
                  OP_APPEND: begin
                     cmd.count_inc = 1'b1;
                     state_in      = S_RESULT;
                  end
                  OP_DEL_VERTEX: begin
                     cmd.row_init = 1'b1;
                     state_in     = S_SHIFT_CHECK;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_EDGE_WR_A: begin
            cmd.addr_sel = ADDR_SRC;
            cmd.wr_op    = edge_wr;
            state_in     = S_EDGE_RD_B;
         end
         S_EDGE_RD_B: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_TGT;
            state_in     = S_EDGE_WR_B;
         end
         S_EDGE_WR_B: begin
            cmd.addr_sel = ADDR_TGT;
            cmd.wr_op    = edge_wr;
            state_in     = S_RESULT;
         end
         S_QUERY_ANS: begin
            cmd.answer_edge = 1'b1;
            state_in        = S_RESULT;
         end
         S_PATH_PICK: begin
            cmd.rd_en = 1'b1;
            if (status.pending_any) begin
               cmd.addr_sel = ADDR_PICK;
               cmd.pick     = 1'b1;
               state_in     = S_PATH_MERGE;
            end else begin
               cmd.addr_sel = ADDR_TGT;
               state_in     = S_PATH_ANS;
            end
         end
         S_PATH_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = S_PATH_PICK;
         end
         S_PATH_ANS: begin
            cmd.answer_path = 1'b1;
            state_in        = S_RESULT;
         end
         S_SHIFT_CHECK: begin
            if (status.shift_more) begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_SHIFT_RD;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.drop_last = 1'b1;
               state_in      = S_RESULT;
            end
         end
         S_SHIFT_WR: begin
            cmd.addr_sel = ADDR_SHIFT_WR;
            cmd.wr_op    = WR_SHIFT;
            cmd.row_step = 1'b1;
            state_in     = S_SHIFT_CHECK;
         end
         S_RESULT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decode only ever follows an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE) |-> $past(req_valid && !req_stall))
      else $error("decode entered without an accepted transaction");

   // a config load and an item load never share a cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.cfg_load |-> (!cmd.item_load && state_ff == S_IDLE))
      else $error("config load outside idle or alongside an item");

   // the matrix is read and written in separate cycles
   assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op != WR_NONE) |-> !cmd.rd_en)
      else $error("matrix read and write in the same cycle");

endmodule

// ----- hdl/ugip_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugip_dpath: adjacency matrix and working registers
// Row memory with per-row valid bits, frontier registers, vertex count and
// the result register.
// ----------------------------------------------------------------------------
module ugip_dpath
   import ugip_pkg::*;
#(
   parameter int MAX_VERTICES = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  ugip_cmd_type    cmd,
   output ugip_status_type status,
   input  logic [5:0]      csr_initial_vertex_count,
   input  logic [2:0]      req_opcode,
   input  logic [4:0]      req_source_vertex,
   input  logic [4:0]      req_target_vertex,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_answer,
   output logic [1:0]      rsp_error_code,
   output logic [5:0]      rsp_vertex_count
);

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [6:0] MAX_V7 = 7'(MAX_VERTICES);

   // matrix storage
   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_ok_ff;

   // item and working registers
   logic [CW-1:0]           count_ff, count_in;
   logic [2:0]              op_ff;
   logic [4:0]              src_ff, tgt_ff;
   logic [1:0]              err_ff, err_in;
   logic                    answer_ff;
   logic [MAX_VERTICES-1:0] reach_ff, expanded_ff;
   logic [VW-1:0]           row_ff;

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_answer_ff;
   logic [1:0]              rsp_error_ff;
   logic [5:0]              rsp_count_ff;

   logic [6:0]              n7, cfg7;
   logic                    s_bad, t_bad;
   logic [VW-1:0]           src_idx, tgt_idx, pick_idx, addr, last_idx, other_idx;
   logic [MAX_VERTICES-1:0] pending, rdata, up, shifted, wr_mask, wr_data, src_bit;
   logic                    wr_en;

   assign n7       = 7'(count_ff);
   assign cfg7     = 7'(csr_initial_vertex_count);
   assign s_bad    = 7'(req_source_vertex) >= n7;
   assign t_bad    = 7'(req_target_vertex) >= n7;
   assign src_idx  = VW'(src_ff);
   assign tgt_idx  = VW'(tgt_ff);
   assign last_idx = VW'(n7 - 7'd1);
   assign src_bit  = MAX_VERTICES'(1) << src_idx;
   assign pending  = reach_ff & ~expanded_ff;
   assign rdata    = rd_ok_ff ? rd_data_ff : '0;

   // check the transaction against the count as it is taken
   always_comb begin
      err_in = ERR_OK;
      unique case (req_opcode)
         OP_ADD_EDGE, OP_DEL_EDGE, OP_EDGE_QUERY, OP_PATH_QUERY: begin
            if (s_bad || t_bad) err_in = ERR_INDEX;
         end
         OP_APPEND: begin
            if (n7 >= MAX_V7) err_in = ERR_FULL;
         end
         OP_DEL_VERTEX: begin
            if (s_bad) err_in = ERR_INDEX;
         end
         default: begin
            err_in = ERR_OK;
         end
      endcase
   end

   // lowest unexpanded vertex of the frontier
   always_comb begin
      pick_idx = '0;
      for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
         if (pending[j]) pick_idx = VW'(j);
      end
   end

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_SRC:      addr = src_idx;
         ADDR_TGT:      addr = tgt_idx;
         ADDR_PICK:     addr = pick_idx;
         ADDR_SHIFT_RD: addr = (row_ff < src_idx) ? row_ff : VW'(row_ff + 1'b1);
         ADDR_SHIFT_WR: addr = row_ff;
         default:       addr = src_idx;
      endcase
   end

   // drop the column of the removed vertex
   assign up = rdata >> 1;
   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         shifted[j] = (VW'(j) < src_idx) ? rdata[j] : up[j];
      end
   end

   assign other_idx = (cmd.addr_sel == ADDR_TGT) ? src_idx : tgt_idx;
   assign wr_mask   = MAX_VERTICES'(1) << other_idx;
   assign wr_en     = (cmd.wr_op != WR_NONE);

   always_comb begin
      unique case (cmd.wr_op)
         WR_SET:   wr_data = rdata | wr_mask;
         WR_CLR:   wr_data = rdata & ~wr_mask;
         WR_SHIFT: wr_data = shifted;
         default:  wr_data = rdata;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cfg_load) begin
         count_in = (cfg7 > MAX_V7) ? CW'(MAX_V7) : CW'(cfg7);
      end else if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.drop_last) begin
         count_in = count_ff - 1'b1;
      end
   end

   // memory array and read register
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
         rd_ok_ff   <= row_valid_ff[addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.cfg_load) begin
            row_valid_ff <= '0;
         end else begin
            if (wr_en)         row_valid_ff[addr]     <= 1'b1;
            if (cmd.drop_last) row_valid_ff[last_idx] <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_ff     <= req_opcode;
         src_ff    <= req_source_vertex;
         tgt_ff    <= req_target_vertex;
         err_ff    <= err_in;
         answer_ff <= 1'b0;
      end
      if (cmd.answer_edge) answer_ff <= rdata[tgt_idx];
      if (cmd.answer_path) answer_ff <= |(reach_ff & ~src_bit & rdata);
      if (cmd.reach_init) begin
         reach_ff    <= src_bit;
         expanded_ff <= '0;
      end
      if (cmd.pick)  expanded_ff <= expanded_ff | (MAX_VERTICES'(1) << pick_idx);
      if (cmd.merge) reach_ff    <= reach_ff | rdata;
      if (cmd.row_init) row_ff <= '0;
      if (cmd.row_step) row_ff <= row_ff + 1'b1;
      if (cmd.rsp_load) begin
         rsp_answer_ff <= answer_ff;
         rsp_error_ff  <= err_ff;
         rsp_count_ff  <= 6'(count_ff);
      end
   end

   assign status.op          = op_ff;
   assign status.err         = err_ff;
   assign status.pending_any = |pending;
   assign status.shift_more  = (7'(row_ff) + 7'd1) < n7;
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer       = rsp_answer_ff;
   assign rsp_error_code   = rsp_error_ff;
   assign rsp_vertex_count = rsp_count_ff;

   assert property (@(posedge clock) disable iff (reset)
      n7 <= MAX_V7)
      else $error("vertex count above capacity");

   // rows at or above the count never hold data
   assert property (@(posedge clock) disable iff (reset)
      (row_valid_ff >> count_ff) == '0)
      else $error("valid row above the vertex count");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.merge || cmd.pick) |-> ((expanded_ff & ~reach_ff) == '0))
      else $error("expanded vertex outside the reached set");

   // a new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

// ----- hdl/undirected_graph_indirect_path.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undirected_graph_indirect_path: graph store with indirect-path queries
// Symmetric bit adjacency matrix, vertex add/remove and reachability search.
// ----------------------------------------------------------------------------
// The block holds an undirected graph of up to MAX_VERTICES vertices as one
// row of bits per vertex, kept in a single-port row memory with a valid bit
// per row (reset and a config write invalidate all rows at once, so no
// clearing pass is needed). One transaction is processed at a time and
// every transaction returns exactly one response. Append, unused opcodes
// and any error go straight to the result; an edge query reads the source
// row; add/remove edge reads and writes the source row, then the target
// row; a path query reads one row per vertex reachable from the source
// and merges it into the frontier, then reads the target row; remove
// vertex reads each surviving row, squeezes its column out and writes it
// back. The response sits in an output register, so a new transaction is
// taken while the previous response is still stalled; the block only
// waits for that register when its next response is ready.
// Writing csr_initial_vertex_count (idle only, csr_ready high) clears all
// edges and loads the vertex count, saturated to MAX_VERTICES.
// ----------------------------------------------------------------------------
module undirected_graph_indirect_path
   import ugip_pkg::*;
#(
   parameter int MAX_VERTICES = 32
) (
   input  logic       clock,
   input  logic       reset,
   // configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_initial_vertex_count,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [4:0] req_source_vertex,
   input  logic [4:0] req_target_vertex,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_answer,
   output logic [1:0] rsp_error_code,
   output logic [5:0] rsp_vertex_count
);

   ugip_cmd_type    cmd;
   ugip_status_type status;

   // sequencer: walks each transaction through its states
   ugip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // matrix, frontier and result registers
   ugip_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .csr_initial_vertex_count (csr_initial_vertex_count),
      .req_opcode               (req_opcode),
      .req_source_vertex        (req_source_vertex),
      .req_target_vertex        (req_target_vertex),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_answer               (rsp_answer),
      .rsp_error_code           (rsp_error_code),
      .rsp_vertex_count         (rsp_vertex_count)
   );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for undirected_graph_indirect_path
// Sends graph commands (edge edits, edge and path queries, vertex append and
// removal) through the request channel and predicts every response with an
// in-bench copy of the adjacency matrix. Each response is checked field by
// field in order, while the sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench
   import ugip_pkg::*;
();

   localparam int MAX_VERTICES   = 32;
   // this pause outlasts any transaction still in flight, even a path query
   // over a fully reached graph or a removal at full size
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 5000;

   // opcodes the block leaves unused; they must answer zero with no error
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic       answer;
      logic [1:0] error_code;
      logic [5:0] vertex_count;
   } graph_result_type;

   // ------------------------------------------------------------------------
   // Block inputs start at known values; reset is high from time zero
   // ------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic [5:0] csr_initial_vertex_count = '0;
   logic       req_valid = 1'b0;
   logic [2:0] req_opcode = '0;
   logic [4:0] req_source_vertex = '0;
   logic [4:0] req_target_vertex = '0;
   logic       rsp_stall = 1'b0;

   logic       csr_ready;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_answer;
   logic [1:0] rsp_error_code;
   logic [5:0] rsp_vertex_count;

   // ------------------------------------------------------------------------
   // Graph model: one bit row per vertex plus the live vertex count
   // ------------------------------------------------------------------------
   logic [MAX_VERTICES-1:0] adjacency [MAX_VERTICES];
   int unsigned             graph_size;
   graph_result_type        expected_results [$];

   int mismatch_count    = 0;
   int requests_sent     = 0;
   int responses_checked = 0;
   int path_queries      = 0;
   int paths_found       = 0;
   int csr_writes        = 0;
   int idle_pct          = 0;
   int stall_pct         = 0;
   int quiet_cycles      = 0;

   undirected_graph_indirect_path #(
      .MAX_VERTICES(MAX_VERTICES)
   ) uut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_initial_vertex_count(csr_initial_vertex_count),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_opcode              (req_opcode),
      .req_source_vertex       (req_source_vertex),
      .req_target_vertex       (req_target_vertex),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_answer              (rsp_answer),
      .rsp_error_code          (rsp_error_code),
      .rsp_vertex_count        (rsp_vertex_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model update functions
   // ------------------------------------------------------------------------

   // A count write clears every edge and loads the count, clipped to the
   // matrix size.
   function automatic void load_vertex_count(logic [5:0] value);
      int unsigned loaded;
      loaded = (value > MAX_VERTICES) ? MAX_VERTICES : value;
      foreach (adjacency[r]) adjacency[r] = '0;
      graph_size = loaded;
   endfunction

   // Grow the reachable set from the source until it stops changing, then
   // ask whether any reached vertex other than the source touches the target.
   function automatic logic has_indirect_path(int unsigned src, int unsigned dst);
      logic [MAX_VERTICES-1:0] reach;
      logic [MAX_VERTICES-1:0] grown;
      int unsigned             round;
      int unsigned             v;
      reach = '0;
      reach[src] = 1'b1;
      for (round = 0; round < MAX_VERTICES; round++) begin
         grown = reach;
         for (v = 0; v < MAX_VERTICES; v++) begin
            if (reach[v]) grown |= adjacency[v];
         end
         if (grown == reach) break;
         reach = grown;
      end
      reach[src] = 1'b0;
      return |(reach & adjacency[dst]);
   endfunction

   // Drop one vertex: move the higher rows down, then squeeze its column out
   // of every surviving row.
   function automatic void drop_vertex(int unsigned idx);
      logic [MAX_VERTICES-1:0] below;
      logic [MAX_VERTICES-1:0] row;
      int unsigned             r;
      below = (32'd1 << idx) - 32'd1;
      for (r = idx; r + 1 < graph_size; r++) adjacency[r] = adjacency[r + 1];
      adjacency[graph_size - 1] = '0;
      for (r = 0; r + 1 < graph_size; r++) begin
         row = adjacency[r];
         adjacency[r] = (row & below) | ((row >> (idx + 1)) << idx);
      end
      graph_size--;
   endfunction

   // Apply one command to the model and return the response it must cause.
   function automatic graph_result_type apply_graph_op(logic [2:0] op, logic [4:0] src,
                                                      logic [4:0] dst);
      graph_result_type res;
      res = '0;
      res.error_code = ERR_OK;
      case (op)
         OP_ADD_EDGE, OP_DEL_EDGE, OP_EDGE_QUERY, OP_PATH_QUERY: begin
            if (src >= graph_size || dst >= graph_size) begin
               res.error_code = ERR_INDEX;
            end else if (op == OP_ADD_EDGE) begin
               adjacency[src][dst] = 1'b1;
               adjacency[dst][src] = 1'b1;
            end else if (op == OP_DEL_EDGE) begin
               adjacency[src][dst] = 1'b0;
               adjacency[dst][src] = 1'b0;
            end else if (op == OP_EDGE_QUERY) begin
               res.answer = adjacency[src][dst];
            end else begin
               res.answer = has_indirect_path(src, dst);
               path_queries++;
               if (res.answer) paths_found++;
            end
         end
         OP_APPEND: begin
            if (graph_size >= MAX_VERTICES) res.error_code = ERR_FULL;
            else graph_size++;
         end
         OP_DEL_VERTEX: begin
            if (src >= graph_size) res.error_code = ERR_INDEX;
            else drop_vertex(src);
         end
         default: begin
         end
      endcase
      res.vertex_count = graph_size[5:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [4:0] pick_vertex();
      if (graph_size == 0) return 5'($urandom_range(31));
      return 5'($urandom_range(graph_size - 1));
   endfunction

   // Mostly in-range commands so edges build up and path searches go deep;
   // a slice of fully random commands covers bad indices and spare opcodes.
   function automatic void choose_graph_command(output logic [2:0] op,
                                                output logic [4:0] src,
                                                output logic [4:0] dst);
      int unsigned roll;
      roll = $urandom_range(99);
      src = pick_vertex();
      dst = pick_vertex();
      if (roll < 22) op = OP_ADD_EDGE;
      else if (roll < 35) op = OP_DEL_EDGE;
      else if (roll < 49) op = OP_EDGE_QUERY;
      else if (roll < 73) op = OP_PATH_QUERY;
      else if (roll < 80) op = OP_APPEND;
      else if (roll < 87) op = OP_DEL_VERTEX;
      else if (roll < 90) op = ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
      else begin
         op  = 3'($urandom_range(7));
         src = 5'($urandom_range(31));
         dst = 5'($urandom_range(31));
      end
   endfunction

   // Offer one transaction and hold it until accepted. Valid stays high on
   // return so back-to-back items never drop it within one time step; the
   // idle loop or settle_graph lowers it.
   task automatic send_request(logic [2:0] op, logic [4:0] src, logic [4:0] dst);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_source_vertex <= src;
      req_target_vertex <= dst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(apply_graph_op(op, src, dst));
      requests_sent++;
   endtask

   // Drop valid, wait for every response, then let any tail work finish.
   task automatic settle_graph();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [5:0] value);
      csr_valid                <= 1'b1;
      csr_initial_vertex_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      load_vertex_count(value);
      csr_writes++;
   endtask

   // ------------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------------

   // Empty graph: every indexed command fails, spare opcodes do nothing,
   // then grow to one vertex and shrink back to none.
   task automatic test_empty_graph();
      settle_graph();
      idle_pct  = 0;
      stall_pct = 0;
      write_vertex_count(6'd0);
      send_request(OP_ADD_EDGE, 5'd31, 5'd31);
      send_request(OP_PATH_QUERY, 5'd0, 5'd0);
      send_request(OP_DEL_VERTEX, 5'd0, 5'd31);
      send_request(OP_SPARE_6, 5'd31, 5'd31);
      send_request(OP_SPARE_7, 5'd0, 5'd0);
      send_request(OP_APPEND, 5'd31, 5'd0);
      send_request(OP_EDGE_QUERY, 5'd0, 5'd0);
      send_request(OP_DEL_VERTEX, 5'd0, 5'd0);
   endtask

   // Oversized write clips to a full matrix: append is refused, the corner
   // vertices and a self loop are exercised, then the ends are removed.
   task automatic test_full_matrix();
      settle_graph();
      write_vertex_count(6'd63);
      send_request(OP_APPEND, 5'd0, 5'd0);
      send_request(OP_ADD_EDGE, 5'd0, 5'd31);
      send_request(OP_ADD_EDGE, 5'd31, 5'd31);
      send_request(OP_EDGE_QUERY, 5'd31, 5'd0);
      send_request(OP_PATH_QUERY, 5'd0, 5'd31);
      send_request(OP_PATH_QUERY, 5'd31, 5'd0);
      send_request(OP_DEL_EDGE, 5'd31, 5'd0);
      send_request(OP_DEL_VERTEX, 5'd31, 5'd0);
      send_request(OP_EDGE_QUERY, 5'd30, 5'd31);
      send_request(OP_DEL_VERTEX, 5'd0, 5'd31);
   endtask

   // Chain 0-1-2-3 with vertex 4 isolated: a long path, a dead end, then a
   // removal that renumbers the chain.
   task automatic test_chain_removal();
      settle_graph();
      write_vertex_count(6'd5);
      send_request(OP_ADD_EDGE, 5'd0, 5'd1);
      send_request(OP_ADD_EDGE, 5'd1, 5'd2);
      send_request(OP_ADD_EDGE, 5'd2, 5'd3);
      send_request(OP_PATH_QUERY, 5'd0, 5'd3);
      send_request(OP_PATH_QUERY, 5'd4, 5'd0);
      send_request(OP_DEL_VERTEX, 5'd0, 5'd0);
      send_request(OP_EDGE_QUERY, 5'd1, 5'd2);
   endtask

   task automatic test_random_traffic(logic [5:0] start_count, int sender_idle,
                                      int receiver_stall, int items);
      logic [2:0] op;
      logic [4:0] src;
      logic [4:0] dst;
      settle_graph();
      write_vertex_count(start_count);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      repeat (items) begin
         choose_graph_command(op, src, dst);
         send_request(op, src, dst);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response checker, receiver stall and watchdog
   // ------------------------------------------------------------------------
   function automatic void flag_mismatch(string field, logic [5:0] want, logic [5:0] got);
      mismatch_count++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
   endfunction

   always @(posedge clock) begin : response_check
      graph_result_type want;
      if (!reset) begin
         // compare an accepted response with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $error("response arrived with no transaction outstanding");
            end else begin
               want = expected_results.pop_front();
               responses_checked++;
               if (rsp_answer !== want.answer)
                  flag_mismatch("answer", want.answer, rsp_answer);
               if (rsp_error_code !== want.error_code)
                  flag_mismatch("error_code", want.error_code, rsp_error_code);
               if (rsp_vertex_count !== want.vertex_count)
                  flag_mismatch("vertex_count", want.vertex_count, rsp_vertex_count);
            end
         end
         // any handshake on any channel counts as progress
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d responses outstanding",
                  quiet_cycles, expected_results.size());
         $display("undirected_graph_indirect_path test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset once, directed corners, then random traffic under
   // four idling profiles (none, sender gaps, receiver stalls, both)
   // ------------------------------------------------------------------------
   initial begin
      load_vertex_count(6'd0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_graph();
      test_full_matrix();
      test_chain_removal();
      test_random_traffic(6'd32, 0, 0, 200);
      test_random_traffic(6'd12, 70, 0, 200);
      test_random_traffic(6'd1, 0, 70, 200);
      test_random_traffic(6'd20, 21, 21, 200);
      settle_graph();

      $display("Checked %0d responses to %0d graph commands across %0d count settings;",
               responses_checked, requests_sent, csr_writes);
      $display("%0d path queries, %0d of them found an indirect path.",
               path_queries, paths_found);
      if (mismatch_count == 0) begin
         $display("undirected_graph_indirect_path test passed");
      end else begin
         $display("undirected_graph_indirect_path test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ugip_pkg.sv
hdl/ugip_ctrl.sv
hdl/ugip_dpath.sv
hdl/undirected_graph_indirect_path.sv
verif/testbench.sv
